/* rtl/core/swec_pkg.sv */
// Package for the sliding window event counter.
// Holds operation and register codes, reset values, the scan state type and
// the control/status words between the top level and the timestamp store.
`default_nettype none

package swec_pkg;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_EXPIRE = 1'b1;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_MAX    = 1'b1;

	localparam logic [31:0] WINDOW_RESET = 32'd100;
	localparam logic [7:0]  MAX_RESET    = 8'd100;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} store_ctl_t;

	typedef struct packed {
		logic empty;
		logic last;
		logic room;
	} store_sts_t;

endpackage

`default_nettype wire

/* rtl/core/sliding_window_event_counter.sv */
// Sliding window event counter: top level with command handshake and scan FSM.
// Add, or expire on an empty store, gives its result in the cycle after start.
// Expire on a non-empty store scans, popping expired heads until one has not expired or the store empties;
// one entry is checked per cycle against the head read from the stamp memory.
// busy is high only during the scan; a new start is taken in the result cycle.
// Reset clears pointers, count and last stamp, registers to 100; memory not cleared.
`default_nettype none

module sliding_window_event_counter
	import swec_pkg::*;
#(
	parameter int STORE_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [63:0] event_time,
	input  wire logic [63:0] current_time,
	output logic             strobe,
	output logic      [7:0]  entry_count,
	output logic             accepted
);

	state_t      state_q;
	state_t      state_next;
	logic [31:0] window_q;
	logic [7:0]  max_q;
	logic [63:0] last_q;
	logic [63:0] now_q;
	logic        strobe_q;
	logic        accepted_q;
	logic [63:0] head_stamp;
	logic        expired;
	logic        done;
	store_ctl_t  ctl;
	store_sts_t  sts;

	swec_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.wdata      (event_time),
		.max_entries(max_q),
		.head_stamp (head_stamp),
		.sts        (sts),
		.entry_count(entry_count)
	);

	assign expired = (now_q > head_stamp) && ((now_q - head_stamp) > {32'd0, window_q});

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && (op == OP_EXPIRE) && !sts.empty) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!expired || sts.last) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.push = 1'b0;
		ctl.pop  = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.push = (op == OP_ADD) && (event_time != last_q) && sts.room;
					done     = (op == OP_ADD) || sts.empty;
				end
			end
			ST_SCAN: begin
				ctl.pop = expired;
				done    = !expired || sts.last;
			end
			default: begin
				ctl.push = 1'b0;
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign strobe   = strobe_q;
	assign accepted = accepted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= WINDOW_RESET;
			max_q      <= MAX_RESET;
			last_q     <= '0;
			strobe_q   <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			state_q    <= state_next;
			strobe_q   <= done;
			accepted_q <= ctl.push;
			if (ctl.push) begin
				last_q <= event_time;
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_WINDOW: window_q <= cfg_wdata;
					REG_MAX:    max_q    <= cfg_wdata[7:0];
					default:    window_q <= window_q;
				endcase
			end
		end
	end

	// hold the scan time
	always_ff @(posedge clk) begin
		if (!busy && start) begin
			now_q <= current_time;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/swec_store.sv */
// Timestamp FIFO of the sliding window event counter.
// Owns the synchronous stamp memory, its pointers and the fill count.
// Depends on swec_pkg for the control and status words.
`default_nettype none

module swec_store
	import swec_pkg::*;
#(
	parameter int STORE_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire store_ctl_t  ctl,
	input  wire logic [63:0] wdata,
	input  wire logic [7:0]  max_entries,
	output logic      [63:0] head_stamp,
	output store_sts_t       sts,
	output logic      [7:0]  entry_count
);

	localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

	logic [63:0]      mem [STORE_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] rd_next;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_addr;
	logic [EXT_W-1:0] count_ext;
	logic [EXT_W-1:0] max_ext;

	assign rd_next = (rd_ptr_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_next = (wr_ptr_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_addr = ctl.pop ? rd_next : rd_ptr_q;

	assign count_ext   = EXT_W'(count_q);
	assign max_ext     = EXT_W'(max_entries);
	assign entry_count = count_ext[7:0];

	assign sts.empty = (count_q == '0);
	assign sts.last  = (count_q == CNT_W'(1));
	assign sts.room  = sts.empty ||
		((count_ext < max_ext) && (count_q < CNT_W'(STORE_DEPTH)));

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// forward a word written to the slot being read
	always_ff @(posedge clk) begin
		if (ctl.push && (wr_ptr_q == rd_addr)) begin
			head_stamp <= wdata;
		end else begin
			head_stamp <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_next;
				count_q  <= count_q + 1'b1;
			end else if (ctl.pop) begin
				rd_ptr_q <= rd_next;
				count_q  <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Testbench for the sliding window event counter top level.
// Sends add and expire words through start/busy, predicts every result with a local
// model of the timestamp FIFO and checks it on strobe; depends on swec_pkg.
module testbench;
	import swec_pkg::*;

	localparam int DEPTH = 128;
	localparam int STALL_LIMIT = 2000;
	localparam logic [63:0] TOP_STAMP = '1;

	typedef struct packed {
		logic [7:0] count;
		logic       stored;
	} tally_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = REG_WINDOW;
	logic [31:0] cfg_wdata = '0;
	logic        start = 1'b0;
	logic        op = OP_ADD;
	logic [63:0] event_time = '0;
	logic [63:0] current_time = '0;
	logic        busy;
	logic        strobe;
	logic [7:0]  entry_count;
	logic        accepted;

	logic [63:0] stamp_ring [DEPTH];
	int unsigned head_idx = 0;
	int unsigned tail_idx = 0;
	int unsigned fill_level = 0;
	logic [63:0] newest_stamp = '0;
	logic [31:0] win_len = WINDOW_RESET;
	logic [7:0]  cap_entries = MAX_RESET;
	tally_t      expected_tallies [$];

	int unsigned idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned stamps_stored = 0;
	int unsigned peak_fill = 0;
	int unsigned longest_purge = 0;
	int unsigned quiet_cycles = 0;

	sliding_window_event_counter #(.STORE_DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.event_time   (event_time),
		.current_time (current_time),
		.strobe       (strobe),
		.entry_count  (entry_count),
		.accepted     (accepted)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic tally_t predict_tally(logic cmd, logic [63:0] stamp, logic [63:0] now);
		tally_t      t;
		int unsigned popped;
		t.stored = 1'b0;
		popped = 0;
		if (cmd == OP_ADD) begin
			if (stamp != newest_stamp && (fill_level == 0 ||
					(fill_level < cap_entries && fill_level < DEPTH))) begin
				stamp_ring[tail_idx] = stamp;
				tail_idx = (tail_idx + 1) % DEPTH;
				fill_level++;
				newest_stamp = stamp;
				t.stored = 1'b1;
				stamps_stored++;
			end
		end else begin
			while (fill_level > 0 && now > stamp_ring[head_idx] &&
					now - stamp_ring[head_idx] > {32'd0, win_len}) begin
				head_idx = (head_idx + 1) % DEPTH;
				fill_level--;
				popped++;
			end
		end
		if (fill_level > peak_fill)
			peak_fill = fill_level;
		if (popped > longest_purge)
			longest_purge = popped;
		t.count = fill_level[7:0];
		return t;
	endfunction

	always @(posedge clk) begin
		tally_t want;
		if (strobe) begin
			if (expected_tallies.size() == 0) begin
				flag_error($sformatf("unexpected result: count %0d accepted %0b",
					entry_count, accepted));
			end else begin
				want = expected_tallies.pop_front();
				results_seen++;
				if (entry_count !== want.count || accepted !== want.stored)
					flag_error($sformatf(
						"result %0d: expected count %0d accepted %0b, got count %0d accepted %0b",
						results_seen, want.count, want.stored, entry_count, accepted));
			end
		end
		if (cfg_we) begin
			if (cfg_addr == REG_WINDOW)
				win_len = cfg_wdata;
			else
				cap_entries = cfg_wdata[7:0];
		end
		if (arst_n && start && !busy)
			expected_tallies.push_back(predict_tally(op, event_time, current_time));
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic issue_word(logic cmd, logic [63:0] stamp, logic [63:0] now);
		int unsigned gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= cmd;
		event_time <= stamp;
		current_time <= now;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (expected_tallies.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_edges();
		issue_word(OP_ADD, 64'd0, wide_random());
		issue_word(OP_EXPIRE, wide_random(), 64'd0);
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP);
		issue_word(OP_ADD, 64'd5, wide_random());
		issue_word(OP_ADD, 64'd5, wide_random());
		issue_word(OP_ADD, 64'd3, wide_random());
		issue_word(OP_EXPIRE, wide_random(), 64'd105);
		issue_word(OP_EXPIRE, wide_random(), 64'd106);
		issue_word(OP_ADD, TOP_STAMP - 1, wide_random());
		// hold until every result is back before touching the window
		drain_results();
		write_register(REG_WINDOW, 32'hFFFF_FFFF);
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP);
		write_register(REG_WINDOW, 32'd0);
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP - 1);
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP);
	endtask

	task automatic test_entry_limits();
		write_register(REG_MAX, 32'd0);
		issue_word(OP_ADD, 64'd10, wide_random());
		issue_word(OP_ADD, 64'd11, wide_random());
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP);
		write_register(REG_MAX, 32'd1);
		issue_word(OP_ADD, 64'd20, wide_random());
		issue_word(OP_ADD, TOP_STAMP, wide_random());
		issue_word(OP_ADD, 64'd21, wide_random());
		issue_word(OP_EXPIRE, wide_random(), 64'd21);
		write_register(REG_WINDOW, 32'd100);
		write_register(REG_MAX, 32'd2);
		issue_word(OP_ADD, 64'd30, wide_random());
		issue_word(OP_ADD, 64'd31, wide_random());
		issue_word(OP_ADD, 64'd32, wide_random());
		issue_word(OP_EXPIRE, wide_random(), 64'd200);
	endtask

	task automatic test_random_traffic(logic [31:0] window, logic [7:0] limit,
			int unsigned add_pct, int unsigned noise_pct, int unsigned step_max,
			int unsigned count, int unsigned idle, logic [63:0] base);
		logic [63:0] clock_now;
		logic [63:0] prior;
		logic [63:0] pick;
		write_register(REG_WINDOW, window);
		write_register(REG_MAX, {24'd0, limit});
		idle_pct = idle;
		clock_now = base;
		prior = base;
		repeat (count) begin
			if ($urandom_range(99) < noise_pct) begin
				issue_word(1'($urandom_range(1)), wide_random(), wide_random());
			end else if ($urandom_range(99) < add_pct) begin
				clock_now += $urandom_range(step_max);
				pick = ($urandom_range(9) == 0) ? prior : clock_now;
				prior = pick;
				issue_word(OP_ADD, pick, wide_random());
			end else begin
				issue_word(OP_EXPIRE, wide_random(), clock_now + $urandom_range(step_max));
			end
		end
		idle_pct = 0;
	endtask

	task automatic test_top_of_time();
		issue_word(OP_ADD, TOP_STAMP, wide_random());
		issue_word(OP_ADD, TOP_STAMP, wide_random());
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_entry_limits();
		test_random_traffic(32'd100, 8'd100, 60, 8, 30, 130, 0, 64'($urandom));
		test_random_traffic(32'd20, 8'd8, 65, 8, 10, 130, 61, 64'($urandom));
		test_random_traffic(32'hFFFF_FFFF, 8'd128, 92, 0, 1000, 180, 37, 64'd1000);
		issue_word(OP_EXPIRE, wide_random(), TOP_STAMP);
		test_random_traffic(32'd0, 8'd1, 50, 8, 3, 100, 0,
			{32'hFFFF_FFFF, 32'd0} + $urandom_range(1000));
		test_random_traffic(32'd5000, 8'd200, 70, 8, 200, 120, 61, 64'($urandom));
		test_top_of_time();
		drain_results();
		repeat (DEPTH + 4) @(posedge clk);
		if (expected_tallies.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_tallies.size()));
		$display("Sent %0d add/expire words, %0d timestamps stored, %0d results checked.",
			words_sent, stamps_stored, results_seen);
		$display("Peak fill %0d of %0d, longest purge %0d entries, %0d mismatches.",
			peak_fill, DEPTH, longest_purge, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
